FILE: hw/rtl/drss_pkg.sv
`default_nettype none

package drss_pkg;

	localparam int unsigned CODE_BITS        = 12;
	localparam int unsigned DUR_BITS         = 6;
	localparam int unsigned HOLD_BITS        = 6;
	localparam int unsigned FRAME_BITS       = 24;
	localparam int unsigned FRAME_PAD        = 16 - CODE_BITS;
	localparam int unsigned MAX_DURATION_DEF = 62;

	localparam logic [7:0]              CMD_WRITE  = 8'h30;
	localparam logic [DUR_BITS-1:0]     HOLD_SLACK = DUR_BITS'(3);
	localparam logic [CODE_BITS-1:0]    CODE_MAX   = {CODE_BITS{1'b1}};

	typedef logic signed [CODE_BITS:0]   acc_t;
	typedef logic signed [CODE_BITS+1:0] sum_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_START,
		ST_RAMP,
		ST_FLAT
	} seq_state_t;

	typedef struct packed {
		logic                 done;
		logic                 busy;
		logic [CODE_BITS-1:0] quotient;
	} div_rsp_t;

	function automatic logic [CODE_BITS-1:0] sat_code(input sum_t v);
		logic [CODE_BITS-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > sum_t'({1'b0, CODE_MAX})) begin
			r = CODE_MAX;
		end else begin
			r = v[CODE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/drss_seg_if.sv
`default_nettype none

interface drss_seg_if import drss_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] start_code;
	logic [CODE_BITS-1:0] end_code;
	logic [DUR_BITS-1:0]  duration;
	logic [CODE_BITS-1:0] next_start_code;
	logic                 last_segment;

	modport source (
		output valid, start_code, end_code, duration, next_start_code, last_segment,
		input  ready
	);
	modport sink (
		input  valid, start_code, end_code, duration, next_start_code, last_segment,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/drss_dac_if.sv
`default_nettype none

interface drss_dac_if import drss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CODE_BITS-1:0]  dac_code;
	logic [FRAME_BITS-1:0] dac_frame;
	logic [HOLD_BITS-1:0]  hold_units;
	logic                  segment_end;
	logic                  profile_done;

	modport source (
		output valid, dac_code, dac_frame, hold_units, segment_end, profile_done,
		input  ready
	);
	modport sink (
		input  valid, dac_code, dac_frame, hold_units, segment_end, profile_done,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/drss_divider.sv
`default_nettype none

module drss_divider import drss_pkg::*; #(
	parameter int unsigned DIV_W = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [CODE_BITS-1:0] dividend,
	input  wire logic [DIV_W-1:0]     divisor,
	output div_rsp_t                  rsp
);

	localparam int unsigned CW = $clog2(CODE_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [CODE_BITS-1:0] quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvs_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] rem_n;

	always_comb begin
		shifted = {rem_q, quo_q[CODE_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
		rem_n   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CODE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CODE_BITS-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dac_ramp_segment_sequencer.sv
// Channel  Modport  Item
// seg      sink     one profile segment: start, end, duration, next start, last flag
// dac      source   one DAC write: code, 24-bit frame, hold, segment end, profile done
//
// Flat segment: one result, which carries the hold; the next seg waits until it is emitted.
// Ramp segment: a restoring divider yields the step, then one result per cycle while dac
// is free for the start code and duration+1 ramp codes, duration capped at MAX_DURATION.
// Reset clears the sequencer, the divider control and the output valid.
// A stalled dac channel holds the sequencer; seg is taken only when idle.
`default_nettype none

module dac_ramp_segment_sequencer import drss_pkg::*; #(
	parameter int unsigned MAX_DURATION = MAX_DURATION_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	drss_seg_if.sink    seg,
	drss_dac_if.source  dac
);

	localparam int unsigned          CNT_W   = $clog2(MAX_DURATION + 2);
	localparam logic [DUR_BITS-1:0]  DUR_CAP = DUR_BITS'(MAX_DURATION);

	seq_state_t state_q, state_d;

	acc_t                 run_q;
	acc_t                 step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     steps_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic                 neg_q;
	logic                 last_q;

	logic                  out_valid_q;
	logic [CODE_BITS-1:0]  code_q;
	logic [HOLD_BITS-1:0]  hold_out_q;
	logic                  seg_end_q;
	logic                  done_q;

	logic                 accept;
	logic                 out_free;
	logic                 emit;
	logic                 is_ramp;
	logic                 is_neg;
	logic [DUR_BITS-1:0]  dur_cl;
	logic [HOLD_BITS-1:0] hold_d;
	logic [CODE_BITS-1:0] mag;
	logic [CNT_W-1:0]     steps_d;
	sum_t                 sum;
	acc_t                 step_d;
	logic [CODE_BITS-1:0] emit_code;
	logic [HOLD_BITS-1:0] emit_hold;
	logic                 emit_end;
	logic                 last_step;
	div_rsp_t             div_rsp;

	always_comb begin
		dur_cl  = (seg.duration > DUR_CAP) ? DUR_CAP : seg.duration;
		is_ramp = seg.start_code != seg.end_code;
		is_neg  = seg.end_code < seg.start_code;
		mag     = is_neg ? (seg.start_code - seg.end_code) : (seg.end_code - seg.start_code);
		steps_d = CNT_W'(dur_cl) + CNT_W'(1);
		hold_d  = ((dur_cl > HOLD_SLACK) ? HOLD_BITS'(dur_cl - HOLD_SLACK) : '0)
			+ HOLD_BITS'(seg.next_start_code != seg.start_code);
		step_d  = neg_q ? -acc_t'({1'b0, div_rsp.quotient})
			: acc_t'({1'b0, div_rsp.quotient});
		sum     = sum_t'(run_q) + sum_t'(step_q);
	end

	drss_divider #(
		.DIV_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && is_ramp),
		.dividend (mag),
		.divisor  (steps_d),
		.rsp      (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = is_ramp ? ST_DIV : ST_FLAT;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (out_free) begin
					state_d = ST_RAMP;
				end
			end
			ST_RAMP: begin
				if (out_free && last_step) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLAT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		seg.ready = state_q == ST_IDLE;
		accept    = seg.valid && seg.ready;
		out_free  = !out_valid_q || dac.ready;
		last_step = cnt_q == CNT_W'(1);
		emit      = 1'b0;
		emit_code = sat_code(sum_t'(run_q));
		emit_hold = '0;
		emit_end  = 1'b0;
		unique case (state_q)
			ST_START: begin
				emit = out_free;
			end
			ST_RAMP: begin
				emit      = out_free;
				emit_code = sat_code(sum);
				emit_end  = last_step;
			end
			ST_FLAT: begin
				emit      = out_free;
				emit_hold = hold_q;
				emit_end  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (dac.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_START && out_free) begin
				cnt_q <= steps_q;
			end else if (state_q == ST_RAMP && out_free) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_q   <= acc_t'({1'b0, seg.start_code});
			steps_q <= steps_d;
			hold_q  <= hold_d;
			neg_q   <= is_neg;
			last_q  <= seg.last_segment;
		end else if (state_q == ST_RAMP && out_free) begin
			run_q <= sum[CODE_BITS:0];
		end
		if (div_rsp.done) begin
			step_q <= step_d;
		end
		if (emit) begin
			code_q     <= emit_code;
			hold_out_q <= emit_hold;
			seg_end_q  <= emit_end;
			done_q     <= emit_end && last_q;
		end
	end

	assign dac.valid        = out_valid_q;
	assign dac.dac_code     = code_q;
	assign dac.dac_frame    = {CMD_WRITE, code_q, {FRAME_PAD{1'b0}}};
	assign dac.hold_units   = hold_out_q;
	assign dac.segment_end  = seg_end_q;
	assign dac.profile_done = done_q;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside division state");

	a_ramp_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RAMP |-> cnt_q != '0)
		else $error("ramp state with no steps left");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE && (state_q == ST_FLAT || div_rsp.busy))
		else $error("accepted item did not start work");

	a_hold_only_flat: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_q != ST_FLAT |-> emit_hold == '0)
		else $error("hold on a ramp result");
`endif

endmodule

`default_nettype wire

FILE: sim/dac_ramp_segment_sequencer_checker.sv
`default_nettype none

module dac_ramp_segment_sequencer_checker import drss_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	drss_seg_if         seg,
	drss_dac_if         dac,
	output int unsigned mismatches,
	output int unsigned pending
);

	typedef struct packed {
		logic [CODE_BITS-1:0]  code;
		logic [FRAME_BITS-1:0] frame;
		logic [HOLD_BITS-1:0]  hold;
		logic                  seg_end;
		logic                  done;
	} dac_write_t;

	dac_write_t          writes_due[$];
	dac_write_t          want;
	dac_write_t          seen;
	acc_t                level;
	acc_t                slope;
	logic [DUR_BITS-1:0] steps_left;

	function automatic dac_write_t dac_write(input sum_t v, input logic [HOLD_BITS-1:0] hold,
			input logic seg_end, input logic last);
		dac_write_t w;
		if (v < 0) begin
			w.code = '0;
		end else if (v > sum_t'(CODE_MAX)) begin
			w.code = CODE_MAX;
		end else begin
			w.code = v[CODE_BITS-1:0];
		end
		w.frame   = {CMD_WRITE, w.code, {FRAME_PAD{1'b0}}};
		w.hold    = hold;
		w.seg_end = seg_end;
		w.done    = seg_end & last;
		return w;
	endfunction

	task automatic predict_segment(input logic [CODE_BITS-1:0] s, e, input logic [DUR_BITS-1:0] d,
			input logic [CODE_BITS-1:0] n, input logic last);
		logic [DUR_BITS-1:0]  span;
		logic [HOLD_BITS-1:0] hold;
		sum_t                 diff;
		sum_t                 sum;
		span  = (d > MAX_DURATION_DEF) ? DUR_BITS'(MAX_DURATION_DEF) : d;
		level = acc_t'({1'b0, s});
		if (s != e) begin
			diff  = sum_t'({2'b00, e}) - sum_t'({2'b00, s});
			slope = acc_t'(diff / sum_t'({1'b0, span} + 7'd1));
			writes_due.push_back(dac_write(sum_t'(level), '0, 1'b0, last));
			steps_left = span + 1'b1;
			while (steps_left != '0) begin
				sum        = sum_t'(level) + sum_t'(slope);
				steps_left = steps_left - 1'b1;
				writes_due.push_back(dac_write(sum, '0, steps_left == '0, last));
				level = acc_t'(sum);
			end
			// hold the clipped final code
			level = acc_t'({1'b0, writes_due[$].code});
		end else begin
			slope = '0;
			hold  = (span > HOLD_SLACK) ? span - HOLD_SLACK : '0;
			if (n != s) begin
				hold = hold + 1'b1;
			end
			writes_due.push_back(dac_write(sum_t'(level), hold, 1'b1, last));
			steps_left = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writes_due.delete();
			level      = '0;
			slope      = '0;
			steps_left = '0;
			mismatches = 0;
			pending    = 0;
		end else begin
			if (seg.valid && seg.ready) begin
				predict_segment(seg.start_code, seg.end_code, seg.duration,
					seg.next_start_code, seg.last_segment);
			end
			if (dac.valid && dac.ready) begin
				seen = '{dac.dac_code, dac.dac_frame, dac.hold_units, dac.segment_end,
					dac.profile_done};
				if (writes_due.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) begin
						$display("unexpected DAC write: code %0d frame %06h hold %0d end %b done %b",
							seen.code, seen.frame, seen.hold, seen.seg_end, seen.done);
					end
				end else begin
					want = writes_due.pop_front();
					if (seen !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10) begin
							$display("DAC write mismatch: expected code %0d frame %06h hold %0d end %b done %b",
								want.code, want.frame, want.hold, want.seg_end, want.done);
							$display("                    actual   code %0d frame %06h hold %0d end %b done %b",
								seen.code, seen.frame, seen.hold, seen.seg_end, seen.done);
						end
					end
				end
			end
			pending = writes_due.size();
		end
	end

endmodule

`default_nettype wire

FILE: sim/dac_ramp_segment_sequencer_tb.sv
`default_nettype none

module dac_ramp_segment_sequencer_tb import drss_pkg::*; ();

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        steady = 1'b0;
	logic        choke  = 1'b0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;

	drss_seg_if seg ();
	drss_dac_if dac ();

	dac_ramp_segment_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.dac    (dac)
	);

	dac_ramp_segment_sequencer_checker dac_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg        (seg),
		.dac        (dac),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	task automatic send_segment(input logic [CODE_BITS-1:0] s, e, input logic [DUR_BITS-1:0] d,
			input logic [CODE_BITS-1:0] n, input logic last);
		steady = (items_sent >= 150 && items_sent < 210);
		if (items_sent == 100) begin
			choke = 1'b1;
		end
		if (items_sent == 240) begin
			seg.valid <= 1'b0;
			wait (pending == 0);
			@(negedge clk);
		end
		while (!steady && $urandom_range(99) < 27) begin
			seg.valid <= 1'b0;
			@(negedge clk);
		end
		seg.valid           <= 1'b1;
		seg.start_code      <= s;
		seg.end_code        <= e;
		seg.duration        <= d;
		seg.next_start_code <= n;
		seg.last_segment    <= last;
		do @(posedge clk); while (!seg.ready);
		items_sent = items_sent + 1;
		@(negedge clk);
	endtask

	initial begin
		dac.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (choke) begin
				dac.ready <= 1'b0;
				repeat (300) @(negedge clk);
				choke = 1'b0;
			end else begin
				dac.ready <= steady || $urandom_range(99) >= 27;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (seg.valid && seg.ready) || (dac.valid && dac.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == 3000) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CODE_BITS-1:0] pt [0:6];
		logic [CODE_BITS-1:0] nxt;
		logic [DUR_BITS-1:0]  d;
		int unsigned          nseg;
		int unsigned          r;
		int                   k;
		seg.valid           = 1'b0;
		seg.start_code      = '0;
		seg.end_code        = '0;
		seg.duration        = '0;
		seg.next_start_code = '0;
		seg.last_segment    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_segment(12'd0, 12'd0, 6'd0, 12'd0, 1'b0);
		send_segment(12'd0, 12'd0, 6'd3, 12'd0, 1'b0);
		send_segment(12'd0, 12'd0, 6'd4, 12'd1, 1'b0);
		send_segment(12'd4095, 12'd4095, 6'd63, 12'd0, 1'b0);
		send_segment(12'd4095, 12'd4095, 6'd62, 12'd4095, 1'b0);
		send_segment(12'd0, 12'd4095, 6'd0, 12'd4095, 1'b0);
		send_segment(12'd4095, 12'd0, 6'd63, 12'd0, 1'b0);
		send_segment(12'd0, 12'd4095, 6'd62, 12'd4095, 1'b0);
		send_segment(12'd10, 12'd13, 6'd10, 12'd13, 1'b0);
		send_segment(12'd100, 12'd90, 6'd2, 12'd90, 1'b0);
		send_segment(12'd90, 12'd100, 6'd2, 12'd100, 1'b0);
		send_segment(12'hAAA, 12'h555, 6'h2A, 12'h555, 1'b0);
		send_segment(12'h555, 12'hAAA, 6'h15, 12'hAAA, 1'b0);
		send_segment(12'd2048, 12'd2048, 6'd10, 12'd2048, 1'b1);
		send_segment(12'd1, 12'd4094, 6'd5, 12'd4094, 1'b1);
		send_segment(12'd4094, 12'd1, 6'd1, 12'd0, 1'b1);
		send_segment(12'd7, 12'd7, 6'd1, 12'd4095, 1'b0);

		while (items_sent < 320) begin
			if ($urandom_range(99) < 12) begin
				send_segment(12'($urandom), 12'($urandom), 6'($urandom), 12'($urandom),
					1'($urandom));
			end else begin
				nseg = $urandom_range(1, 6);
				for (k = 0; k <= nseg; k++) begin
					r = $urandom_range(99);
					if (k > 0 && r < 35) begin
						pt[k] = pt[k-1];
					end else if (r < 43) begin
						pt[k] = '0;
					end else if (r < 51) begin
						pt[k] = '1;
					end else if (k > 0 && r < 65) begin
						pt[k] = pt[k-1] + 12'($urandom_range(40)) - 12'd20;
					end else begin
						pt[k] = 12'($urandom);
					end
				end
				for (k = 0; k < nseg; k++) begin
					r = $urandom_range(99);
					if (r < 70) begin
						d = 6'($urandom_range(8));
					end else if (r < 90) begin
						d = 6'($urandom_range(40, 9));
					end else begin
						d = 6'($urandom_range(63, 41));
					end
					nxt = pt[k+1];
					if (k == nseg - 1 && $urandom_range(1) == 1) begin
						nxt = 12'($urandom);
					end
					send_segment(pt[k], ($urandom_range(99) < 25) ? pt[k] : pt[k+1], d, nxt,
						k == nseg - 1);
				end
			end
		end
		seg.valid <= 1'b0;

		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/drss_pkg.sv
hw/rtl/drss_seg_if.sv
hw/rtl/drss_dac_if.sv
hw/rtl/drss_divider.sv
hw/rtl/dac_ramp_segment_sequencer.sv
sim/dac_ramp_segment_sequencer_checker.sv
sim/dac_ramp_segment_sequencer_tb.sv
